// File: hw/rtl/bmff_pkg.sv
// ----------------------------------------------------------------------------
// bmff_pkg
// Shared types, codes and helpers for the bit map set/get/find-free unit.
// ----------------------------------------------------------------------------
package bmff_pkg;

    localparam int WORD_BITS  = 32;
    localparam int OFF_W      = 5;     // bit offset within one map word
    localparam int INDEX_W    = 10;    // bit index width
    localparam int CFG_W      = 6;     // words-in-use register width
    localparam int WIDX_W     = 6;     // word index, wide enough for any count in use
    localparam int MAP_SLOTS  = 64;    // entries that can ever be addressed
    localparam int OP_W       = 2;

    localparam logic [WORD_BITS-1:0] FULL_WORD     = 32'hFFFF_FFFF;
    localparam logic [CFG_W-1:0]     WORDS_IN_USE_RST = 6'd32;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_FIND  = 2'd2;
    localparam t_op OP_NONE  = 2'd3;

    typedef logic [WORD_BITS-1:0] t_word;

    // Position of the lowest clear bit; caller checks the word is not full.
    function automatic logic [OFF_W-1:0] lowest_zero(input t_word w);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = OFF_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/bmff_if.sv
// ----------------------------------------------------------------------------
// bmff request / response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface bmff_req_if;
    import bmff_pkg::*;

    logic               valid;
    logic               ready;
    t_op                op;
    logic [INDEX_W-1:0] bit_index;
    logic               bit_value;

    modport source (output valid, output op, output bit_index, output bit_value,
                    input ready);
    modport sink   (input valid, input op, input bit_index, input bit_value,
                    output ready);
endinterface

interface bmff_rsp_if;
    import bmff_pkg::*;

    logic               valid;
    logic               ready;
    logic               bit_read;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               out_of_range;

    modport source (output valid, output bit_read, output found,
                    output found_index, output out_of_range, input ready);
    modport sink   (input valid, input bit_read, input found,
                    input found_index, input out_of_range, output ready);
endinterface

// File: hw/rtl/bmff_word_mem.sv
// ----------------------------------------------------------------------------
// bmff_word_mem
// Map word store: one write port, one registered read port, per-entry valid
// bits so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module bmff_word_mem
    import bmff_pkg::*;
#(
    parameter int NUM_WORDS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [WIDX_W-1:0] i_rd_word,
    output t_word             o_rd_data,
    input  logic              i_wr_en,
    input  logic [WIDX_W-1:0] i_wr_word,
    input  t_word             i_wr_data
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    t_word                 r_mem [NUM_WORDS];
    logic [MAP_SLOTS-1:0]  r_valid;
    t_word                 r_rd_data;
    logic                  r_rd_valid;

    // Storage: no reset, validity tracked separately.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[AW'(i_wr_word)] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[AW'(i_rd_word)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_word] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_word];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: hw/rtl/bitmap_set_get_find_free_unit.sv
// ----------------------------------------------------------------------------
// bitmap_set_get_find_free_unit
// Bit map of 32-bit words with bit write, bit read and find-first-clear.
// ----------------------------------------------------------------------------
// The map lives in a synchronous word memory cleared at reset (through
// per-entry valid bits, so no clearing pass is needed and the unit is ready
// right after reset). One item is handled at a time. A write or read goes
// through three steps: accept and issue the word read, modify or extract,
// then load the result register. A search scans from the start word towards
// the last word in use: the scan reads one map word per cycle through the
// single memory read port, masks bits below the start offset in the first
// word only, and stops at the first word that is not full. An item whose word
// lies beyond the words in use, or with the unused op code, skips the word
// read and leaves the map untouched. Words in use saturates at NUM_WORDS and
// zero makes every index out of range. A new item is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_set_get_find_free_unit
    import bmff_pkg::*;
#(
    parameter int NUM_WORDS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    bmff_req_if.sink         i_req,
    bmff_rsp_if.source       o_rsp
);

    localparam int USED_CAP = (NUM_WORDS < 63) ? NUM_WORDS : 63;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CFG_W-1:0]   r_words_in_use;
    logic [CFG_W-1:0]   used;

    // latched request
    t_op                r_op;
    logic [OFF_W-1:0]   r_off;
    logic               r_val;
    logic               r_first;
    logic [WIDX_W-1:0]  r_cur, n_cur;

    // pending result
    logic               r_bit_read, r_found, r_oor;
    logic [INDEX_W-1:0] r_found_idx;

    // output register
    logic               r_out_valid;
    logic               r_out_bit_read, r_out_found, r_out_oor;
    logic [INDEX_W-1:0] r_out_found_idx;

    // memory ports
    logic               rd_en;
    logic [WIDX_W-1:0]  rd_word;
    t_word              rd_data;
    logic               wr_en;
    t_word              wr_data;

    logic               req_acc;
    logic [WIDX_W-1:0]  req_word;
    logic               req_oor;
    t_word              search_word;
    logic [WIDX_W-1:0]  next_cur;
    logic               out_free;

    // Clamp words in use to the store depth.
    assign used = (r_words_in_use > CFG_W'(USED_CAP)) ? CFG_W'(USED_CAP) : r_words_in_use;

    assign req_acc  = i_req.valid && i_req.ready;
    assign req_word = WIDX_W'(i_req.bit_index[INDEX_W-1:OFF_W]);
    assign req_oor  = (req_word >= used);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign next_cur = r_cur + WIDX_W'(1);

    // First word: treat bits below the start offset as taken.
    assign search_word = r_first
                       ? (rd_data | ((t_word'(1) << r_off) - t_word'(1)))
                       : rd_data;

    // Write back: replace the addressed bit.
    always_comb begin
        wr_data        = rd_data;
        wr_data[r_off] = r_val;
    end

    assign wr_en = (r_state == S_READ) && (r_op == OP_WRITE);

    bmff_word_mem #(
        .NUM_WORDS (NUM_WORDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_word (rd_word),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_word (r_cur),
        .i_wr_data (wr_data)
    );

    // Sequencer: issue reads, step the scan, decide the result.
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        rd_en   = 1'b0;
        rd_word = req_word;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_cur = req_word;
                    if (req_oor || i_req.op == OP_NONE) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
                if (r_op == OP_FIND && search_word == FULL_WORD && next_cur < used) begin
                    // advance to the next word, offset drops to zero
                    rd_en   = 1'b1;
                    rd_word = next_cur;
                    n_cur   = next_cur;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_words_in_use <= WORDS_IN_USE_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_words_in_use <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (req_acc) begin
            r_op        <= i_req.op;
            r_off       <= i_req.bit_index[OFF_W-1:0];
            r_val       <= i_req.bit_value;
            r_first     <= 1'b1;
            r_bit_read  <= 1'b0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_oor       <= req_oor && (i_req.op != OP_NONE);
        end else if (r_state == S_READ) begin
            r_first <= 1'b0;
            if (r_op == OP_READ) begin
                r_bit_read <= rd_data[r_off];
            end
            if (r_op == OP_FIND && search_word != FULL_WORD) begin
                r_found     <= 1'b1;
                r_found_idx <= {r_cur[OFF_W-1:0], lowest_zero(search_word)};
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_bit_read  <= r_bit_read;
            r_out_found     <= r_found;
            r_out_found_idx <= r_found_idx;
            r_out_oor       <= r_oor;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.bit_read     = r_out_bit_read;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.found_index  = r_out_found_idx;
    assign o_rsp.out_of_range = r_out_oor;

    // An out-of-range item reports nothing else.
    a_oor_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.out_of_range |-> !o_rsp.found && !o_rsp.bit_read)
        else $error("out_of_range result carries data");

    // A miss reports index zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.found |-> o_rsp.found_index == '0)
        else $error("found_index set without found");

    // The scan never leaves the words in use.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_cur < used)
        else $error("scan word beyond words in use");

    // A map write happens only for a write item.
    a_write_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_op == OP_WRITE && !r_oor)
        else $error("map write for a non-write item");

endmodule

// File: dv/tb_bitmap_set_get_find_free_unit.sv
// ----------------------------------------------------------------------------
// tb_bitmap_set_get_find_free_unit
// Self-checking bench for the bit map unit: a short table of directed requests,
// then random phases under several words-in-use settings. A shadow bit map
// predicts every untyped result, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_bitmap_set_get_find_free_unit;
    import bmff_pkg::*;

    localparam int NUM_WORDS      = 32;
    localparam int RESET_CYCLES   = 10;
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int DRAIN_CYCLES   = 40;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int N_DIRECTED     = 26;

    typedef struct packed {
        logic               bit_read;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               out_of_range;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed table: a request, or a words-in-use write.
    typedef struct {
        t_row_kind          kind;
        t_op                op;
        logic [INDEX_W-1:0] idx;
        logic               val;
        logic [CFG_W-1:0]   words;
        bit                 typed;     // res below holds the expected result
        t_result            res;
    } t_row;

    localparam t_result RES_ZERO    = '0;
    localparam t_result RES_BIT_SET = '{1'b1, 1'b0, 10'd0, 1'b0};
    localparam t_result RES_OOR     = '{1'b0, 1'b0, 10'd0, 1'b1};
    localparam t_result RES_AT_0    = '{1'b0, 1'b1, 10'd0, 1'b0};
    localparam t_result RES_AT_TOP  = '{1'b0, 1'b1, 10'd1023, 1'b0};

    localparam logic [CFG_W-1:0] PHASE_WORDS [N_PHASES] =
        '{6'd32, 6'd7, 6'd0, 6'd63, 6'd1, 6'd16, 6'd33, 6'd32};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    bmff_req_if req_ch ();
    bmff_rsp_if rsp_ch ();

    // Shadow copy of the map and of the words-in-use register.
    logic [WORD_BITS-1:0] shadow_map [NUM_WORDS];
    logic [CFG_W-1:0]     shadow_words;

    t_result results_due [$];   // predicted results, oldest first
    int      errors = 0;
    int      items_offered = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;       // no idling on either side
    bit      hold_long = 1'b0;  // ask the receiver for one long hold-off

    // Directed requests, starting from the reset state (32 words in use).
    t_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, OP_READ,  10'd0,    1'b0, 6'd0,  1'b1, RES_ZERO},
        '{ROW_ITEM, OP_READ,  10'd1023, 1'b0, 6'd0,  1'b1, RES_ZERO},
        '{ROW_ITEM, OP_FIND,  10'd0,    1'b0, 6'd0,  1'b1, RES_AT_0},
        '{ROW_ITEM, OP_FIND,  10'd1023, 1'b0, 6'd0,  1'b1, RES_AT_TOP},
        '{ROW_ITEM, OP_WRITE, 10'd0,    1'b1, 6'd0,  1'b1, RES_ZERO},
        '{ROW_ITEM, OP_READ,  10'd0,    1'b0, 6'd0,  1'b1, RES_BIT_SET},
        '{ROW_ITEM, OP_FIND,  10'd0,    1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_WRITE, 10'd1023, 1'b1, 6'd0,  1'b1, RES_ZERO},
        // search from the last bit, which is set: nothing found
        '{ROW_ITEM, OP_FIND,  10'd1023, 1'b0, 6'd0,  1'b1, RES_ZERO},
        '{ROW_ITEM, OP_READ,  10'd1023, 1'b1, 6'd0,  1'b1, RES_BIT_SET},
        // unused op code: map untouched, all fields zero
        '{ROW_ITEM, OP_NONE,  10'd1023, 1'b1, 6'd0,  1'b1, RES_ZERO},
        '{ROW_ITEM, OP_WRITE, 10'd31,   1'b1, 6'd0,  1'b0, RES_ZERO},
        // search crosses into the next word from bit 0
        '{ROW_ITEM, OP_FIND,  10'd31,   1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_WRITE, 10'd0,    1'b0, 6'd0,  1'b1, RES_ZERO},
        // no words in use: every index is out of range
        '{ROW_CFG,  OP_NONE,  10'd0,    1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_READ,  10'd0,    1'b0, 6'd0,  1'b1, RES_OOR},
        '{ROW_ITEM, OP_FIND,  10'd0,    1'b0, 6'd0,  1'b1, RES_OOR},
        '{ROW_ITEM, OP_WRITE, 10'd5,    1'b1, 6'd0,  1'b1, RES_OOR},
        '{ROW_CFG,  OP_NONE,  10'd0,    1'b0, 6'd1,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_READ,  10'd32,   1'b0, 6'd0,  1'b1, RES_OOR},
        '{ROW_ITEM, OP_FIND,  10'd31,   1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_WRITE, 10'd31,   1'b0, 6'd0,  1'b0, RES_ZERO},
        // count above the map size saturates
        '{ROW_CFG,  OP_NONE,  10'd0,    1'b0, 6'd63, 1'b0, RES_ZERO},
        '{ROW_ITEM, OP_FIND,  10'd1000, 1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_ITEM, OP_WRITE, 10'd1023, 1'b0, 6'd0,  1'b0, RES_ZERO},
        '{ROW_CFG,  OP_NONE,  10'd0,    1'b0, 6'd32, 1'b0, RES_ZERO}
    };

    bitmap_set_get_find_free_unit #(
        .NUM_WORDS (NUM_WORDS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Words taking part in a request: the register, saturated at the map size.
    function automatic int words_used();
        return (shadow_words > NUM_WORDS) ? NUM_WORDS : int'(shadow_words);
    endfunction

    // Apply one request to the shadow map and return the result it yields.
    function automatic t_result bitmap_apply(t_op op, logic [INDEX_W-1:0] idx,
                                             logic val);
        t_result res;
        int      used;
        int      word;
        int      off;
        int      w;
        int      j;
        res  = '0;
        used = words_used();
        word = int'(idx[INDEX_W-1:OFF_W]);
        off  = int'(idx[OFF_W-1:0]);
        if (op != OP_NONE) begin
            if (word >= used) begin
                res.out_of_range = 1'b1;
            end else if (op == OP_WRITE) begin
                shadow_map[word][off] = val;
            end else if (op == OP_READ) begin
                res.bit_read = shadow_map[word][off];
            end else begin
                // honor the start offset in the first word only
                w = word;
                j = off;
                while (w < used && !res.found) begin
                    while (j < WORD_BITS && !res.found) begin
                        if (!shadow_map[w][j]) begin
                            res.found       = 1'b1;
                            res.found_index = INDEX_W'(w * WORD_BITS + j);
                        end
                        j++;
                    end
                    j = 0;
                    w++;
                end
            end
        end
        return res;
    endfunction

    // Mostly indexes inside the words in use, now and then anywhere.
    function automatic logic [INDEX_W-1:0] pick_index();
        int used;
        used = words_used();
        if (used == 0 || $urandom_range(0, 7) == 0) begin
            return INDEX_W'($urandom_range(0, 1023));
        end
        return INDEX_W'($urandom_range(0, used * WORD_BITS - 1));
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return OP_NONE;
        end else if (r <= 5) begin
            return OP_WRITE;
        end else if (r <= 9) begin
            return OP_READ;
        end
        return OP_FIND;
    endfunction

    // Offer one item, hold it until accepted, then log what it should yield.
    // Called at a rising edge; valid is never lowered and raised in one step.
    task automatic offer_item(t_op op, logic [INDEX_W-1:0] idx, logic val,
                              bit typed, t_result typed_res);
        int      gap;
        t_result pred;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.bit_index <= idx;
        req_ch.bit_value <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        // the item moved at this edge: update the shadow map in step with it
        pred = bitmap_apply(op, idx, val);
        results_due.push_back(typed ? typed_res : pred);
        items_offered++;
    endtask

    // Write words in use once the unit has gone quiet.
    task automatic set_words_in_use(logic [CFG_W-1:0] words);
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        // the last result has left; let the unit settle before the write
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= words;
        @(posedge i_clk);
        shadow_words = words;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        int      phase_end;
        int      used;
        int      w;
        int      hole;
        bit      keep_hole;
        t_op     op;
        logic [CFG_W-1:0] words;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= OP_NONE;
        req_ch.bit_index <= '0;
        req_ch.bit_value <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        for (int k = 0; k < NUM_WORDS; k++) begin
            shadow_map[k] = '0;
        end
        shadow_words = WORDS_IN_USE_RST;

        // hold reset, then release it once
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                set_words_in_use(directed_rows[r].words);
            end else begin
                offer_item(directed_rows[r].op, directed_rows[r].idx,
                           directed_rows[r].val, directed_rows[r].typed,
                           directed_rows[r].res);
            end
        end

        // random phases, one words-in-use setting each; the last one calm
        for (int p = 0; p < N_PHASES; p++) begin
            calm  = (p == N_PHASES - 1);
            words = PHASE_WORDS[p];
            if (p == 5) begin
                words = CFG_W'($urandom_range(2, 31));
            end
            set_words_in_use(words);
            // stall the receiver for a long stretch while items keep coming
            if (p == 1) begin
                hold_long = 1'b1;
            end
            phase_end = items_offered + ((words == 0) ? 40 : PHASE_ITEMS);
            while (items_offered < phase_end) begin
                used = words_used();
                case ($urandom_range(0, 9))
                    0, 1: begin
                        if (used != 0) begin
                            // fill one word, maybe leaving a hole, then search
                            // through it so the scan runs past full words
                            w         = $urandom_range(0, used - 1);
                            hole      = $urandom_range(0, WORD_BITS - 1);
                            keep_hole = 1'($urandom_range(0, 1));
                            for (int b = 0; b < WORD_BITS; b++) begin
                                offer_item(OP_WRITE, INDEX_W'(w * WORD_BITS + b),
                                           !(keep_hole && b == hole), 1'b0,
                                           RES_ZERO);
                            end
                            for (int s = 0; s < 3; s++) begin
                                offer_item(OP_FIND, INDEX_W'(w * WORD_BITS +
                                           $urandom_range(0, WORD_BITS - 1)),
                                           1'($urandom), 1'b0, RES_ZERO);
                            end
                            offer_item(OP_FIND, '0, 1'b0, 1'b0, RES_ZERO);
                        end
                    end
                    2: begin
                        // clear a few bits so the map does not saturate
                        for (int c = 0; c < 6; c++) begin
                            offer_item(OP_WRITE, pick_index(), 1'b0, 1'b0,
                                       RES_ZERO);
                        end
                    end
                    default: begin
                        op = pick_op();
                        offer_item(op, pick_index(),
                                   ($urandom_range(0, 2) != 0), 1'b0, RES_ZERO);
                    end
                endcase
            end
        end

        // drain: wait for every result, then let the unit go quiet
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: toggle ready in random bursts, with one long hold-off on
    // request and no stalls in the calm phase.
    // ------------------------------------------------------------------------
    initial begin
        rsp_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                     want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected, got %0d %0d %0d %0d",
                         $time, rsp_ch.bit_read, rsp_ch.found,
                         rsp_ch.found_index, rsp_ch.out_of_range);
                errors++;
            end else begin
                want = results_due.pop_front();
                check_field("bit_read", want.bit_read, rsp_ch.bit_read);
                check_field("found", want.found, rsp_ch.found);
                check_field("found_index", want.found_index, rsp_ch.found_index);
                check_field("out_of_range", want.out_of_range,
                            rsp_ch.out_of_range);
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
